FILE: hdl/assert_macros.svh
// Assertion macros shared by the error diffusion dither RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define EDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define EDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/edd_pkg.sv
// Types, constants and arithmetic helpers of the error diffusion dither.
// No dependencies; imported by every module of the block.
`default_nettype none

package edd_pkg;

    localparam int LINE_LENGTH_W = 11;
    localparam int THRESHOLD_W   = 8;

    localparam logic [LINE_LENGTH_W-1:0] LINE_LENGTH_RESET = 11'd1024;
    localparam logic [THRESHOLD_W-1:0]   THRESHOLD_RESET   = 8'd128;

    localparam logic CFG_LINE_LENGTH = 1'b0;
    localparam logic CFG_THRESHOLD   = 1'b1;

    // Luma weights in Q16, summing to 65536.
    localparam logic [23:0] LUMA_R     = 24'd19595;
    localparam logic [23:0] LUMA_G     = 24'd38470;
    localparam logic [23:0] LUMA_B     = 24'd7471;
    localparam logic [23:0] LUMA_ROUND = 24'd32768;

    localparam logic [8:0] WHITE_LEVEL = 9'd255;

    typedef logic signed [8:0] t_error;

    typedef struct packed {
        logic first_line;
        logic line_start;
        logic eol;
    } t_scan_flags;

    function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [23:0] acc;
        acc = 24'(r) * LUMA_R + 24'(g) * LUMA_G + 24'(b) * LUMA_B + LUMA_ROUND;
        return acc[23:16];
    endfunction

    // Adds two or three eighths of an error, rounds half up, clamps to 0..255.
    function automatic logic [7:0] add_err(input logic [7:0] v, input t_error e,
                                           input logic three);
        logic signed [12:0] ke;
        logic signed [12:0] t;
        logic signed [9:0]  q;
        logic [7:0]         res;
        ke = three ? (13'(e) + (13'(e) <<< 1)) : (13'(e) <<< 1);
        t  = $signed({2'b00, v, 3'b000}) + ke + 13'sd4;
        q  = t[12:3];
        if (q[9]) begin
            res = 8'd0;
        end else if (q > 10'sd255) begin
            res = 8'hFF;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/edd_line_store.sv
// Line store holding the errors of the previous scan line.
// Uses edd_pkg for the error type; registered read, one write port.
`default_nettype none

module edd_line_store
    import edd_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  t_error                   i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output t_error                   o_rdata
);

    t_error r_mem [DEPTH];
    t_error r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/edd_scan.sv
// Scan position tracker: line position, first line flag and end of line.
// Uses edd_pkg for the flag struct and the line length width.
`default_nettype none

module edd_scan
    import edd_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire                         i_first_of_frame,
    input  wire  [LINE_LENGTH_W-1:0]    i_line_length,
    output logic [$clog2(MAX_LINE)-1:0] o_pos,
    output t_scan_flags                 o_flags
);

    localparam int PW = $clog2(MAX_LINE);
    localparam int CW = ((PW + 1) > LINE_LENGTH_W) ? (PW + 1) : LINE_LENGTH_W;

    logic [PW-1:0] r_position;
    logic [PW-1:0] n_position;
    logic          r_first_line;
    logic          n_first_line;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] pos_inc;
    logic          first_line;

    always_comb begin
        o_pos      = i_first_of_frame ? '0 : r_position;
        first_line = i_first_of_frame | r_first_line;
        len_ext    = CW'(i_line_length);
        if (len_ext == '0) begin
            len_eff = CW'(1);
        end else if (len_ext > CW'(MAX_LINE)) begin
            len_eff = CW'(MAX_LINE);
        end else begin
            len_eff = len_ext;
        end
        pos_inc            = CW'(o_pos) + CW'(1);
        o_flags.first_line = first_line;
        o_flags.line_start = (o_pos == '0);
        o_flags.eol        = (pos_inc >= len_eff);
        n_position         = r_position;
        n_first_line       = r_first_line;
        if (i_accept) begin
            n_position   = o_flags.eol ? '0 : pos_inc[PW-1:0];
            n_first_line = o_flags.eol ? 1'b0 : first_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_first_line <= 1'b1;
        end else begin
            r_position   <= n_position;
            r_first_line <= n_first_line;
        end
    end

`include "assert_macros.svh"

    `EDD_ASSERT_NEXT(a_eol_wraps, i_clk, i_rst_n, i_accept && o_flags.eol,
        (r_position == '0) && !r_first_line, "end of line did not wrap the position")
    `EDD_ASSERT_NEXT(a_pos_steps, i_clk, i_rst_n, i_accept && !o_flags.eol,
        r_position == $past(o_pos) + 1'b1, "position did not advance by one")

endmodule

`default_nettype wire

FILE: hdl/edd_quantize.sv
// Error application and black/white decision for one pixel.
// Uses edd_pkg for add_err, the error type and the flag struct.
`default_nettype none

module edd_quantize
    import edd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_update,
    input  wire  [7:0]             i_luma,
    input  t_error                 i_above,
    input  t_scan_flags            i_flags,
    input  wire  [THRESHOLD_W-1:0] i_threshold,
    output logic                   o_white,
    output t_error                 o_error
);

    t_error     r_diag;
    t_error     r_left;
    logic [7:0] v_diag;
    logic [7:0] v_above;
    logic [7:0] v_left;

    always_comb begin
        v_diag  = (!i_flags.first_line && !i_flags.line_start) ?
                  add_err(i_luma, r_diag, 1'b0) : i_luma;
        v_above = !i_flags.first_line ? add_err(v_diag, i_above, 1'b1) : v_diag;
        v_left  = !i_flags.line_start ? add_err(v_above, r_left, 1'b1) : v_above;
        o_white = (v_left > i_threshold);
        o_error = o_white ? $signed({1'b0, v_left} - WHITE_LEVEL) : $signed({1'b0, v_left});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag <= '0;
            r_left <= '0;
        end else if (i_update) begin
            r_diag <= i_flags.first_line ? t_error'(0) : i_above;
            r_left <= o_error;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/error_diffusion_dither_core.sv
// A pixel goes from the input registers to the decision stage and then to the output register.
// One pixel per clock unless stalled; the left-error feedback closes in the decision stage.
// The previous-line error store is a single-port-write RAM with a one-deep write bypass.
// Reset clears valid bits, scan position and carried errors and restores the configuration
// defaults; the line store is not cleared and is written before it is read within a frame.
`default_nettype none

module error_diffusion_dither_core
    import edd_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire  [7:0]              i_red,
    input  wire  [7:0]              i_green,
    input  wire  [7:0]              i_blue,
    input  wire                     i_first_of_frame,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic                    o_pixel_white,
    output logic                    o_end_of_line,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire                     i_cfg_index,
    input  wire  [LINE_LENGTH_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(MAX_LINE);

    logic [LINE_LENGTH_W-1:0] r_line_length;
    logic [THRESHOLD_W-1:0]   r_threshold;

    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic n_s1_valid;
    logic n_s2_valid;
    logic n_out_valid;
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s2_move;
    logic s1_move;
    logic in_accept;

    logic [PW-1:0] scan_pos;
    t_scan_flags   scan_flags;

    logic [7:0]    r_s1_red;
    logic [7:0]    r_s1_green;
    logic [7:0]    r_s1_blue;
    logic [PW-1:0] r_s1_pos;
    t_scan_flags   r_s1_flags;

    logic [7:0]    r_s2_luma;
    logic [PW-1:0] r_s2_pos;
    t_scan_flags   r_s2_flags;
    logic          r_s2_byp;
    t_error        r_s2_byp_err;

    logic r_out_white;
    logic r_out_eol;

    t_error mem_rdata;
    t_error above;
    logic   q_white;
    t_error q_error;

    assign out_free  = !r_out_valid || !i_stall;
    assign s2_move   = r_s2_valid && out_free;
    assign s2_free   = !r_s2_valid || out_free;
    assign s1_move   = r_s1_valid && s2_free;
    assign s1_free   = !r_s1_valid || s2_free;
    assign in_accept = i_valid && s1_free;
    assign o_stall   = !s1_free;

    assign n_s1_valid  = in_accept || (r_s1_valid && !s1_move);
    assign n_s2_valid  = s1_move || (r_s2_valid && !s2_move);
    assign n_out_valid = s2_move || (r_out_valid && i_stall);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RESET;
            r_threshold   <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_LENGTH: begin
                    r_line_length <= i_cfg_data;
                end
                CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[THRESHOLD_W-1:0];
                end
                default: begin
                    r_threshold <= r_threshold;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    edd_scan #(
        .MAX_LINE(MAX_LINE)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_first_of_frame(i_first_of_frame),
        .i_line_length   (r_line_length),
        .o_pos           (scan_pos),
        .o_flags         (scan_flags)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_pos   <= scan_pos;
            r_s1_flags <= scan_flags;
        end
        if (s1_move) begin
            r_s2_luma    <= luma(r_s1_red, r_s1_green, r_s1_blue);
            r_s2_pos     <= r_s1_pos;
            r_s2_flags   <= r_s1_flags;
            r_s2_byp     <= s2_move && (r_s2_pos == r_s1_pos);
            r_s2_byp_err <= q_error;
        end
        if (s2_move) begin
            r_out_white <= q_white;
            r_out_eol   <= r_s2_flags.eol;
        end
    end

    edd_line_store #(
        .DEPTH(MAX_LINE)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (s2_move),
        .i_waddr(r_s2_pos),
        .i_wdata(q_error),
        .i_re   (s1_move),
        .i_raddr(r_s1_pos),
        .o_rdata(mem_rdata)
    );

    assign above = r_s2_byp ? r_s2_byp_err : mem_rdata;

    edd_quantize u_quantize (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (s2_move),
        .i_luma     (r_s2_luma),
        .i_above    (above),
        .i_flags    (r_s2_flags),
        .i_threshold(r_threshold),
        .o_white    (q_white),
        .o_error    (q_error)
    );

    assign o_valid       = r_out_valid;
    assign o_pixel_white = r_out_white;
    assign o_end_of_line = r_out_eol;

`include "assert_macros.svh"

    `EDD_ASSERT_NEXT(a_s2_to_out, i_clk, i_rst_n, s2_move, r_out_valid,
        "a pixel leaving the decision stage did not reach the output register")
    `EDD_ASSERT_NEXT(a_s2_holds, i_clk, i_rst_n, r_s2_valid && !out_free, r_s2_valid,
        "a stalled pixel was dropped from the decision stage")

endmodule

`default_nettype wire

FILE: bench/error_diffusion_dither_checker.sv
// Checker for the error diffusion dither core: watches the pixel, result and register
// channels, predicts every pixel decision and compares it field by field.
// Depends on edd_pkg for the register indexes, reset values and the error type.
`default_nettype none

module error_diffusion_dither_checker
    import edd_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire                      o_stall,
    input  wire  [7:0]               i_red,
    input  wire  [7:0]               i_green,
    input  wire  [7:0]               i_blue,
    input  wire                      i_first_of_frame,
    input  wire                      o_valid,
    input  wire                      i_stall,
    input  wire                      o_pixel_white,
    input  wire                      o_end_of_line,
    input  wire                      i_cfg_valid,
    input  wire                      o_cfg_ready,
    input  wire                      i_cfg_index,
    input  wire  [LINE_LENGTH_W-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int PW = $clog2(MAX_LINE);

    localparam int LUMA_RED_Q16   = 19595;
    localparam int LUMA_GREEN_Q16 = 38470;
    localparam int LUMA_BLUE_Q16  = 7471;

    typedef struct packed {
        logic white;
        logic eol;
    } t_dither_decision;

    t_error                   line_err [MAX_LINE];
    t_error                   diag_err;
    t_error                   left_err;
    int unsigned              scan_pos;
    logic                     on_first_line;
    logic [LINE_LENGTH_W-1:0] line_len_reg;
    logic [THRESHOLD_W-1:0]   thr_reg;
    t_dither_decision         awaited_decisions[$];
    int                       fails = 0;

    // Adds k eighths of an error to a gray value, rounds half up and clamps to 0..255.
    function automatic int add_eighths(input int v, input t_error e, input int k);
        int ev;
        int t;
        ev = e;
        t  = (v * 8 + k * ev + 4) >>> 3;
        if (t < 0) begin
            t = 0;
        end else if (t > 255) begin
            t = 255;
        end
        return t;
    endfunction

    function automatic t_dither_decision dither_pixel(input logic [7:0] r, input logic [7:0] g,
                                                      input logic [7:0] b, input logic fof);
        int               len;
        int               pos;
        int               v;
        int               err;
        t_error           above;
        t_dither_decision res;
        len = int'(line_len_reg);
        if (len < 1) begin
            len = 1;
        end
        if (len > MAX_LINE) begin
            len = MAX_LINE;
        end
        if (fof) begin
            scan_pos      = 0;
            on_first_line = 1'b1;
            diag_err      = '0;
            left_err      = '0;
        end
        pos = scan_pos;
        if (pos >= MAX_LINE) begin
            pos = MAX_LINE - 1;
        end
        v = (LUMA_RED_Q16 * int'(r) + LUMA_GREEN_Q16 * int'(g) + LUMA_BLUE_Q16 * int'(b)
             + 32768) >>> 16;
        above = '0;
        if (!on_first_line) begin
            above = line_err[pos[PW-1:0]];
            if (pos > 0) begin
                v = add_eighths(v, diag_err, 2);
            end
            v = add_eighths(v, above, 3);
        end
        if (pos > 0) begin
            v = add_eighths(v, left_err, 3);
        end
        res.white = (v > int'(thr_reg));
        err = res.white ? v - 255 : v;
        diag_err               = on_first_line ? t_error'(0) : above;
        line_err[pos[PW-1:0]]  = t_error'(err);
        left_err               = t_error'(err);
        res.eol = (pos + 1 >= len);
        if (res.eol) begin
            scan_pos      = 0;
            on_first_line = 1'b0;
        end else begin
            scan_pos = pos + 1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_dither_decision want;
        if (!i_rst_n) begin
            diag_err      = '0;
            left_err      = '0;
            scan_pos      = 0;
            on_first_line = 1'b1;
            line_len_reg  = LINE_LENGTH_RESET;
            thr_reg       = THRESHOLD_RESET;
            awaited_decisions.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_LENGTH: line_len_reg = i_cfg_data;
                    CFG_THRESHOLD:   thr_reg = i_cfg_data[THRESHOLD_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (awaited_decisions.size() == 0) begin
                    $error("result beat with no pixel outstanding: %0b %0b",
                           o_pixel_white, o_end_of_line);
                    fails++;
                end else begin
                    want = awaited_decisions.pop_front();
                    if (o_pixel_white !== want.white) begin
                        $error("pixel_white: expected %0b, actual %0b", want.white, o_pixel_white);
                        fails++;
                    end
                    if (o_end_of_line !== want.eol) begin
                        $error("end_of_line: expected %0b, actual %0b", want.eol, o_end_of_line);
                        fails++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                awaited_decisions.push_back(dither_pixel(i_red, i_green, i_blue,
                                                         i_first_of_frame));
            end
        end
        o_pending    <= awaited_decisions.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

FILE: bench/error_diffusion_dither_core_test.sv
// Top of the error diffusion dither core bench: clock, reset, pixel and register stimulus
// with random gaps and stalls, and the final verdict.
// Depends on edd_pkg, error_diffusion_dither_core and error_diffusion_dither_checker.
`default_nettype none

module error_diffusion_dither_core_test;
    import edd_pkg::*;

    localparam int MAX_LINE = 1024;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic [7:0]               i_red = '0;
    logic [7:0]               i_green = '0;
    logic [7:0]               i_blue = '0;
    logic                     i_first_of_frame = 1'b0;
    logic                     i_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     i_cfg_index = CFG_LINE_LENGTH;
    logic [LINE_LENGTH_W-1:0] i_cfg_data = '0;
    wire                      o_stall;
    wire                      o_valid;
    wire                      o_pixel_white;
    wire                      o_end_of_line;
    wire                      o_cfg_ready;
    int                       fail_count;
    int                       pending;

    bit steady = 1'b0;
    bit need_new_frame = 1'b0;
    int cur_len = MAX_LINE;
    int frame_safe_len = MAX_LINE;

    error_diffusion_dither_core #(.MAX_LINE(MAX_LINE)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_first_of_frame(i_first_of_frame),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_white   (o_pixel_white),
        .o_end_of_line   (o_end_of_line),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    error_diffusion_dither_checker #(.MAX_LINE(MAX_LINE)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_first_of_frame(i_first_of_frame),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_white   (o_pixel_white),
        .o_end_of_line   (o_end_of_line),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < 6);
    end

    function automatic int clamp_line_length(input int len);
        if (len < 1) begin
            return 1;
        end
        if (len > MAX_LINE) begin
            return MAX_LINE;
        end
        return len;
    endfunction

    // A new frame fixes how much of the line store is valid for the lines that follow.
    task automatic drive_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic fof);
        logic start;
        start = fof || need_new_frame;
        while (!steady && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_red            <= r;
        i_green          <= g;
        i_blue           <= b;
        i_first_of_frame <= start;
        if (start) begin
            frame_safe_len = cur_len;
            need_new_frame = 1'b0;
        end
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Registers change only once the core has drained every outstanding pixel.
    task automatic write_scan_setup(input logic [LINE_LENGTH_W-1:0] len,
                                    input logic [LINE_LENGTH_W-1:0] thr_word);
        int new_len;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LINE_LENGTH;
        i_cfg_data  <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= thr_word;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        new_len = clamp_line_length(int'(len));
        if (new_len > frame_safe_len) begin
            need_new_frame = 1'b1;
        end else begin
            frame_safe_len = new_len;
        end
        cur_len = new_len;
    endtask

    task automatic drive_random_pixel(input logic fof);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
        end
        drive_pixel(r, g, b, fof);
    endtask

    initial begin
        int phase_len [12];
        int count;
        int thr;
        logic fof;
        phase_len = '{3, 1, 16, 0, 7, 1024, 2047, 2, 33, 5, 12, 64};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_scan_setup(11'd4, 11'd128);
        drive_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        drive_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        drive_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        drive_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        drive_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        drive_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd100, 8'd100, 8'd100, 1'b0);
        drive_pixel(8'd129, 8'd129, 8'd129, 1'b0);
        drive_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        drive_pixel(8'd60, 8'd60, 8'd60, 1'b0);

        // The line is shortened while two pixels of it are already out.
        write_scan_setup(11'd2, 11'd0);
        drive_pixel(8'd1, 8'd1, 8'd1, 1'b0);
        drive_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd10, 8'd200, 8'd30, 1'b0);
        drive_pixel(8'd128, 8'd128, 8'd128, 1'b0);

        // A zero length behaves as one pixel per line.
        write_scan_setup(11'd0, 11'h7FF);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: thr = 0;
                1: thr = 255;
                2: thr = 128;
                default: thr = $urandom_range(0, 255);
            endcase
            write_scan_setup(LINE_LENGTH_W'(phase_len[p]),
                             {3'($urandom_range(0, 7)), 8'(thr)});
            steady = (p == 5);
            if (phase_len[p] == 1024) begin
                count = 300;
            end else if (phase_len[p] > 1024) begin
                count = 250;
            end else begin
                count = $urandom_range(40, 90);
            end
            for (int n = 0; n < count; n++) begin
                fof = 1'b0;
                if (cur_len < 100) begin
                    fof = (n == 0) ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 99) < 2);
                end
                drive_random_pixel(fof);
            end
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("error_diffusion_dither_core verification clean");
        end else begin
            $display("error_diffusion_dither_core verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("error_diffusion_dither_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
